// ===== rtl/odd_even_transposition_sorter_defines.svh =====
// ----------------------------------------------------------------------------
// Odd-even transposition sorter assertion macros
// Shared concurrent-assertion shorthands for the sorter RTL.
// ----------------------------------------------------------------------------
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_DEFINES_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OETS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define OETS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/oets_pkg.sv =====
// ----------------------------------------------------------------------------
// Odd-even transposition sorter package
// Sizes, element type, controller states and the command struct.
// ----------------------------------------------------------------------------
package oets_pkg;

	localparam int MAX_ITEMS = 32;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_SORT = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // store the incoming value or mark a drop
		logic sort;     // run one compare-exchange phase
		logic sort_odd; // odd phase: pairs (1,2),(3,4),...
		logic shift;    // move the store down one slot after an output beat
		logic clear;    // empty the set
	} cmd_t;

endpackage

// ===== rtl/oets_datapath.sv =====
// ----------------------------------------------------------------------------
// Odd-even transposition sorter datapath
// Element registers, compare-exchange cells, fill count and drop flag.
// ----------------------------------------------------------------------------
module oets_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  oets_pkg::cmd_t cmd,
	input  oets_pkg::elem_t value,
	output oets_pkg::cnt_t count,
	output oets_pkg::elem_t head,
	output logic          dropped
);
	import oets_pkg::*;

	elem_t store_q [MAX_ITEMS];
	cnt_t  count_q;
	logic  drop_q;
	logic  room;

	assign room    = (count_q < cnt_t'(MAX_ITEMS));
	assign count   = count_q;
	assign head    = store_q[0];
	assign dropped = drop_q;

	// Element row: no reset, entries past the count are never used.
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			store_q[count_q[IDX_W-1:0]] <= value;
		end else if (cmd.sort) begin
			for (int k = 0; k < MAX_ITEMS - 1; k++) begin
				if ((k[0] == cmd.sort_odd) && (cnt_t'(k + 1) < count_q) &&
				    (store_q[k] > store_q[k + 1])) begin
					store_q[k]     <= store_q[k + 1];
					store_q[k + 1] <= store_q[k];
				end
			end
		end else if (cmd.shift) begin
			for (int k = 0; k < MAX_ITEMS - 1; k++) begin
				store_q[k] <= store_q[k + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.load) begin
			if (room) begin
				count_q <= count_q + cnt_t'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/oets_ctrl.sv =====
// ----------------------------------------------------------------------------
// Odd-even transposition sorter controller
// Load / sort / emit sequencer with a shared phase and beat counter.
// ----------------------------------------------------------------------------
module oets_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	input  logic           out_ready,
	input  oets_pkg::cnt_t count,
	output logic           in_ready,
	output logic           out_valid,
	output logic           out_last,
	output oets_pkg::cmd_t cmd
);
	import oets_pkg::*;

	state_t state_q;
	cnt_t   step_q;
	logic   step_last;
	logic   in_beat;
	logic   out_beat;

	assign step_last = (step_q == cnt_t'(count - cnt_t'(1)));
	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign out_last  = out_valid && step_last;
	assign in_beat   = in_valid && in_ready;
	assign out_beat  = out_valid && out_ready;

	always_comb begin
		cmd          = '0;
		cmd.load     = in_beat;
		cmd.sort     = (state_q == ST_SORT);
		cmd.sort_odd = step_q[0];
		cmd.shift    = out_beat;
		cmd.clear    = out_beat && step_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					step_q <= '0;
					if (in_beat && in_last) begin
						state_q <= ST_SORT;
					end
				end
				ST_SORT: begin
					if (step_last) begin
						step_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						step_q <= step_q + cnt_t'(1);
					end
				end
				ST_EMIT: begin
					if (out_beat) begin
						if (step_last) begin
							step_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							step_q <= step_q + cnt_t'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
					step_q  <= '0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/odd_even_transposition_sorter.sv =====
// ----------------------------------------------------------------------------
// Odd-even transposition sorter
// Collects up to MAX_ITEMS signed values, sorts them ascending with
// odd-even transposition phases and streams them back out.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata              tlast        tuser
//  s_axis    in   value[31:0]        end_of_set   -
//  m_axis    out  sorted_value[31:0] final_flag   overflowed
//
// Flow: a set of N kept values is loaded one value per beat (one per cycle
// while s_tvalid is high), then sorted with one compare-exchange phase per
// cycle in the datapath's cell row, then sent out as N output beats at one
// per cycle when m_tready stays high.
// Reset: arst_n clears the controller to loading and empties the count and
// drop flag; element registers are not reset.
// Stalls: s_tready is low during sort and output; a low m_tready holds the
// current output beat and the element row.
// Values beyond MAX_ITEMS are dropped; every output beat of that set then
// carries tuser high.
//
module odd_even_transposition_sorter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sorted_value
	output logic        m_tlast,
	output logic        m_tuser    // [0] overflowed
);
	import oets_pkg::*;

`include "odd_even_transposition_sorter_defines.svh"

	cmd_t  cmd;
	cnt_t  count;
	elem_t head;
	logic  dropped;

	// Sequencer: decides when to load, run a phase, or advance the output.
	oets_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.out_ready (m_tready),
		.count     (count),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.cmd       (cmd)
	);

	// Element row with compare-exchange cells; slot 0 feeds the output.
	oets_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.value   (elem_t'(s_tdata)),
		.count   (count),
		.head    (head),
		.dropped (dropped)
	);

	assign m_tdata = 32'(head);
	assign m_tuser = dropped;

	// Input and output never open together.
	`OETS_ASSERT_SAME(a_no_overlap, clk, arst_n, m_tvalid, !s_tready, "load and emit overlap")

	// The final output beat hands the block back to loading.
	`OETS_ASSERT_NEXT(a_back_to_load, clk, arst_n, m_tvalid && m_tready && m_tlast,
		s_tready && !m_tvalid, "no return to load after final beat")

	// A set always gets at least one sort phase before any output.
	`OETS_ASSERT_NEXT(a_sort_first, clk, arst_n, s_tvalid && s_tready && s_tlast,
		!s_tready && !m_tvalid, "output or load right after end of set")

endmodule
